FILE: sv/swt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor watch table package
// Shared types and codes of the sensor watch table.
// ----------------------------------------------------------------------------

package swt_pkg;

  // At most this many notifications are given by one tick.
  localparam int unsigned RESULT_LIMIT = 16;
  localparam int unsigned FIRE_CNT_W   = 5;

  typedef enum logic {
    MODE_SUBSCRIBE = 1'b0,
    MODE_TICK      = 1'b1
  } mode_e;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_NOTIFY = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STAT_ADDED = 2'd0,
    STAT_DUP   = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // One stored watch entry.
  typedef struct packed {
    logic [7:0] subscriber;
    logic [4:0] sensor;
    logic       level;
  } entry_t;

endpackage

FILE: sv/sensor_watch_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor watch table unit
// Table of watch entries with subscribe and tick scan, results strobed out.
// ----------------------------------------------------------------------------
// After acceptance a request runs through the scan state, which reads the
// entry memory one slot at a time, the drain state, in which the last read
// returns, and the done state, which closes the request. A new request
// is accepted in the cycle after the final result is registered.
// Results leave one per cycle and the receiver cannot stall. Reset clears all
// valid marks at once; the entry memory itself is not cleared.

module sensor_watch_table_unit #(
  parameter int unsigned TABLE_DEPTH  = 16,
  parameter int unsigned SENSOR_COUNT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [7:0]  subscriber_i,
  input  logic [4:0]  sensor_number_i,
  input  logic        expected_level_i,
  input  logic [31:0] sensor_levels_i,
  output logic        result_valid_o,
  output logic        kind_o,
  output logic [1:0]  status_o,
  output logic [3:0]  slot_o,
  output logic [4:0]  fired_sensor_o,
  output logic        last_o
);

  // Slot index width; a single-slot table still needs one index bit.
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [AW-1:0] LastSlot = AW'(TABLE_DEPTH - 1);
  // Sensors at or above SENSOR_COUNT always read level 0.
  localparam logic [31:0] SensorMask = 32'((64'd1 << SENSOR_COUNT) - 64'd1);

  // Request state and latched request fields.
  swt_pkg::state_e state_q, state_d;
  swt_pkg::mode_e  mode_q;
  swt_pkg::entry_t req_q;
  logic [31:0]     levels_q;

  // Read side of the entry memory.
  swt_pkg::entry_t mem [TABLE_DEPTH];
  logic [AW-1:0]   iss_q, iss_d;
  logic            rd_vld_q;
  logic [AW-1:0]   rd_idx_q;
  swt_pkg::entry_t rd_data_q;
  logic            mem_we;

  // Valid marks live in flip-flops so that reset frees every slot at once.
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;

  // Scan bookkeeping.
  logic                          dup_found_q, dup_found_d;
  logic [AW-1:0]                 dup_slot_q, dup_slot_d;
  logic                          free_found_q, free_found_d;
  logic [AW-1:0]                 free_slot_q, free_slot_d;
  logic [swt_pkg::FIRE_CNT_W-1:0] fire_cnt_q, fire_cnt_d;

  // A notification is held back one step so that the final one can carry last.
  logic          pend_vld_q, pend_vld_d;
  logic [AW-1:0] pend_slot_q, pend_slot_d;
  logic [4:0]    pend_sensor_q, pend_sensor_d;

  // Result register.
  logic            res_vld_q, res_vld_d;
  swt_pkg::kind_e  res_kind_q, res_kind_d;
  swt_pkg::status_e res_status_q, res_status_d;
  logic [3:0]      res_slot_q, res_slot_d;
  logic [4:0]      res_sensor_q, res_sensor_d;
  logic            res_last_q, res_last_d;

  logic accept;
  logic cur_valid;
  logic sub_hit;
  logic fire;

  assign busy   = (state_q != swt_pkg::ST_IDLE);
  assign accept = start && !busy;

  // Compare stage on the entry that returned from memory this cycle.
  assign cur_valid = valid_q[rd_idx_q];
  assign sub_hit   = rd_vld_q && (mode_q == swt_pkg::MODE_SUBSCRIBE) && cur_valid &&
                     (rd_data_q == req_q);
  assign fire      = rd_vld_q && (mode_q == swt_pkg::MODE_TICK) && cur_valid &&
                     (levels_q[rd_data_q.sensor] == rd_data_q.level) &&
                     (fire_cnt_q < swt_pkg::FIRE_CNT_W'(swt_pkg::RESULT_LIMIT));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swt_pkg::ST_IDLE:  if (start) state_d = swt_pkg::ST_SCAN;
      swt_pkg::ST_SCAN:  if (iss_q == LastSlot) state_d = swt_pkg::ST_DRAIN;
      swt_pkg::ST_DRAIN: state_d = swt_pkg::ST_DONE;
      swt_pkg::ST_DONE:  state_d = swt_pkg::ST_IDLE;
      default:           state_d = swt_pkg::ST_IDLE;
    endcase
  end

  // Scan datapath and results.
  always_comb begin
    iss_d         = iss_q;
    valid_d       = valid_q;
    dup_found_d   = dup_found_q;
    dup_slot_d    = dup_slot_q;
    free_found_d  = free_found_q;
    free_slot_d   = free_slot_q;
    fire_cnt_d    = fire_cnt_q;
    pend_vld_d    = pend_vld_q;
    pend_slot_d   = pend_slot_q;
    pend_sensor_d = pend_sensor_q;
    mem_we        = 1'b0;
    res_vld_d     = 1'b0;
    res_kind_d    = swt_pkg::KIND_NOTIFY;
    res_status_d  = swt_pkg::STAT_ADDED;
    res_slot_d    = 4'd0;
    res_sensor_d  = 5'd0;
    res_last_d    = 1'b0;

    if (accept) begin
      iss_d        = '0;
      dup_found_d  = 1'b0;
      free_found_d = 1'b0;
      fire_cnt_d   = '0;
      pend_vld_d   = 1'b0;
    end

    if (state_q == swt_pkg::ST_SCAN && iss_q != LastSlot) begin
      iss_d = iss_q + AW'(1);
    end

    // Subscribe: remember the first duplicate and the lowest free slot.
    if (sub_hit && !dup_found_q) begin
      dup_found_d = 1'b1;
      dup_slot_d  = rd_idx_q;
    end
    if (rd_vld_q && mode_q == swt_pkg::MODE_SUBSCRIBE && !cur_valid && !free_found_q) begin
      free_found_d = 1'b1;
      free_slot_d  = rd_idx_q;
    end

    // Tick: a firing entry is freed and queued; the one before it goes out.
    if (fire) begin
      valid_d[rd_idx_q] = 1'b0;
      fire_cnt_d        = fire_cnt_q + swt_pkg::FIRE_CNT_W'(1);
      pend_vld_d        = 1'b1;
      pend_slot_d       = rd_idx_q;
      pend_sensor_d     = rd_data_q.sensor;
      if (pend_vld_q) begin
        res_vld_d    = 1'b1;
        res_kind_d   = swt_pkg::KIND_NOTIFY;
        res_slot_d   = 4'(pend_slot_q);
        res_sensor_d = pend_sensor_q;
      end
    end

    if (state_q == swt_pkg::ST_DONE) begin
      pend_vld_d = 1'b0;
      if (mode_q == swt_pkg::MODE_SUBSCRIBE) begin
        res_vld_d  = 1'b1;
        res_kind_d = swt_pkg::KIND_STATUS;
        res_last_d = 1'b1;
        if (dup_found_q) begin
          res_status_d = swt_pkg::STAT_DUP;
          res_slot_d   = 4'(dup_slot_q);
        end else if (free_found_q) begin
          mem_we                 = 1'b1;
          valid_d[free_slot_q]   = 1'b1;
          res_status_d           = swt_pkg::STAT_ADDED;
          res_slot_d             = 4'(free_slot_q);
        end else begin
          res_status_d = swt_pkg::STAT_FULL;
        end
      end else if (pend_vld_q) begin
        res_vld_d    = 1'b1;
        res_kind_d   = swt_pkg::KIND_NOTIFY;
        res_slot_d   = 4'(pend_slot_q);
        res_sensor_d = pend_sensor_q;
        res_last_d   = 1'b1;
      end
    end
  end

  // Entry memory: one write port used at the end of a subscribe, one
  // registered read port used during the scan. They are never active together.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[free_slot_q] <= req_q;
    end
    rd_data_q <= mem[iss_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= swt_pkg::ST_IDLE;
      valid_q      <= '0;
      rd_vld_q     <= 1'b0;
      dup_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      fire_cnt_q   <= '0;
      pend_vld_q   <= 1'b0;
      res_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      rd_vld_q     <= (state_q == swt_pkg::ST_SCAN);
      dup_found_q  <= dup_found_d;
      free_found_q <= free_found_d;
      fire_cnt_q   <= fire_cnt_d;
      pend_vld_q   <= pend_vld_d;
      res_vld_q    <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q             <= swt_pkg::mode_e'(mode_i);
      req_q.subscriber   <= subscriber_i;
      req_q.sensor       <= sensor_number_i;
      req_q.level        <= expected_level_i;
      levels_q           <= sensor_levels_i & SensorMask;
    end
    iss_q         <= iss_d;
    rd_idx_q      <= iss_q;
    dup_slot_q    <= dup_slot_d;
    free_slot_q   <= free_slot_d;
    pend_slot_q   <= pend_slot_d;
    pend_sensor_q <= pend_sensor_d;
    res_kind_q    <= res_kind_d;
    res_status_q  <= res_status_d;
    res_slot_q    <= res_slot_d;
    res_sensor_q  <= res_sensor_d;
    res_last_q    <= res_last_d;
  end

  assign result_valid_o = res_vld_q;
  assign kind_o         = res_kind_q;
  assign status_o       = res_status_q;
  assign slot_o         = res_slot_q;
  assign fired_sensor_o = res_sensor_q;
  assign last_o         = res_last_q;

  // Results only come out of work that was in progress.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without a request in progress");

  // The final result of a request is shown once the block is idle again.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> !busy)
    else $error("final result while still busy");

  // A subscribe gives exactly one result, so it is always the last.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o == swt_pkg::KIND_STATUS |-> last_o)
    else $error("status result not marked last");

  // No held-back notification survives the end of a request.
  a_no_stale_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == swt_pkg::ST_IDLE |-> !pend_vld_q)
    else $error("pending notification left in idle");

endmodule
